// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/lnle_pkg.sv =====
package lnle_pkg;

   localparam int MAX_NAME_CHARS = 50;

   localparam int CHAR_W    = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0] CH_NUL     = 7'h00;
   localparam logic [CHAR_W-1:0] CH_TAB     = 7'h09;
   localparam logic [CHAR_W-1:0] CH_LF      = 7'h0A;
   localparam logic [CHAR_W-1:0] CH_FF      = 7'h0C;
   localparam logic [CHAR_W-1:0] CH_CR      = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 7'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7A;
   localparam logic [CHAR_W-1:0] CASE_DELTA = 7'h20;

   localparam logic [CHAR_W-1:0] INTR_RESET  = 7'd127;
   localparam logic [CHAR_W-1:0] EOF_RESET   = 7'd4;
   localparam logic [CHAR_W-1:0] KILL_RESET  = 7'd21;
   localparam logic [CHAR_W-1:0] ERASE_RESET = 7'd8;

   localparam logic [CSR_IDX_W-1:0] CSR_INTR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EOF   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KILL  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE = 2'd3;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_INTR = 1'b1;

   typedef enum logic [1:0] {
      KIND_ECHO   = 2'd0,
      KIND_PROMPT = 2'd1,
      KIND_NAME   = 2'd2,
      KIND_SPEED  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KILL_LF,
      ST_PROMPT,
      ST_NAME
   } state_type;

   typedef struct packed {
      logic       op;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAR_W-1:0] out_char;
      logic              lowercase_mode;
      logic              cr_mode;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              clear;
      logic              shift;
      logic              push;
      logic              pop;
      logic [CHAR_W-1:0] push_char;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/login_name_line_editor_unit.sv =====
// login name line editor
// req channel: one request per received byte (op = 0) or interrupt event (op = 1).
// rsp channel: echo, prompt-again, name and next-speed results; last marks the end
// of the results caused by one request.
// csr port: intr, eof, kill and erase characters, written with csr_we.
// the name sits in a row of MAX_NAME_CHARS cells, filled in order; a completed name
// is shifted out of cell 0, one character per cycle while rsp is not stalled.
// the first result of a request is registered: on rsp in the cycle after acceptance.
// a request with no or one result does not hold the block; a request with several
// results holds it until its last result is made, and a full name gives
// MAX_NAME_CHARS + 1 results; the next request is taken when the previous run has
// left the output register or is being taken from it.
// a stalled rsp holds its result and pauses the run; req_ready stays low meanwhile.
// reset: synchronous; clears the name, case flags, pending interrupt and output,
// and loads the default control characters.
module login_name_line_editor_unit #(
   parameter int MAX_NAME_CHARS = lnle_pkg::MAX_NAME_CHARS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lnle_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lnle_pkg::rsp_type              rsp_data,
   input  logic                           csr_we,
   input  logic [lnle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lnle_pkg::CHAR_W-1:0]    csr_wdata
);

   logic [lnle_pkg::CHAR_W-1:0] intr_ff;
   logic [lnle_pkg::CHAR_W-1:0] eof_ff;
   logic [lnle_pkg::CHAR_W-1:0] kill_ff;
   logic [lnle_pkg::CHAR_W-1:0] erase_ff;

   lnle_pkg::state_type state_ff;
   lnle_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   lnle_pkg::rsp_type   rsp_data_ff;
   lnle_pkg::rsp_type   rsp_data_in;
   logic                upper_ff;
   logic                upper_in;
   logic                lower_ff;
   logic                lower_in;
   logic                pend_ff;
   logic                pend_in;
   logic                fold_ff;
   logic                fold_in;
   logic                crm_ff;
   logic                crm_in;

   lnle_pkg::cell_ctl_type      ctl;
   logic                        occ      [MAX_NAME_CHARS];
   logic                        occ_prev [MAX_NAME_CHARS];
   logic                        occ_next [MAX_NAME_CHARS];
   logic [lnle_pkg::CHAR_W-1:0] chr      [MAX_NAME_CHARS];
   logic [lnle_pkg::CHAR_W-1:0] chr_next [MAX_NAME_CHARS];

   logic                        slot_free;
   logic                        req_fire;
   logic [lnle_pkg::CHAR_W-1:0] c;
   logic                        is_empty;
   logic                        is_speed;
   logic                        is_blank;
   logic [lnle_pkg::CHAR_W-1:0] head_char;
   logic                        head_last;

   genvar g;
   generate
      for (g = 0; g < MAX_NAME_CHARS; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign occ_prev[g] = 1'b1;
         end else begin : g_mid
            assign occ_prev[g] = occ[g-1];
         end
         if (g == MAX_NAME_CHARS - 1) begin : g_end
            assign occ_next[g] = 1'b0;
            assign chr_next[g] = '0;
         end else begin : g_inner
            assign occ_next[g] = occ[g+1];
            assign chr_next[g] = chr[g+1];
         end
         lnle_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .prev_occ  (occ_prev[g]),
            .next_occ  (occ_next[g]),
            .next_char (chr_next[g]),
            .occ       (occ[g]),
            .char_out  (chr[g])
         );
      end
   endgenerate

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == lnle_pkg::ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign c         = req_data.char_in[lnle_pkg::CHAR_W-1:0];
   assign is_empty  = !occ[0];
   assign is_speed  = (c == lnle_pkg::CH_NUL) || (c == intr_ff) || pend_ff ||
                      (is_empty && (c == eof_ff));
   assign is_blank  = (c == lnle_pkg::CH_SPACE) || (c == lnle_pkg::CH_TAB) ||
                      (c == lnle_pkg::CH_FF);
   assign head_last = !occ_next[0];

   always_comb begin
      head_char = chr[0];
      if (fold_ff && (head_char inside {[lnle_pkg::CH_UPPER_A:lnle_pkg::CH_UPPER_Z]})) begin
         head_char = head_char + lnle_pkg::CASE_DELTA;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      upper_in     = upper_ff;
      lower_in     = lower_ff;
      pend_in      = pend_ff;
      fold_in      = fold_ff;
      crm_in       = crm_ff;
      ctl          = '0;
      ctl.push_char = c;

      case (state_ff)
         lnle_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.op == lnle_pkg::OP_INTR) begin
                  pend_in = 1'b1;
               end else if (is_speed) begin
                  ctl.clear    = 1'b1;
                  upper_in     = 1'b0;
                  lower_in     = 1'b0;
                  pend_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{lnle_pkg::KIND_SPEED, '0, 1'b0, 1'b0, 1'b1};
               end else if (is_blank) begin
                  // skipped
               end else if (c == kill_ff) begin
                  ctl.clear    = 1'b1;
                  upper_in     = 1'b0;
                  lower_in     = 1'b0;
                  pend_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{lnle_pkg::KIND_ECHO, lnle_pkg::CH_CR, 1'b0, 1'b0, 1'b0};
                  state_in     = lnle_pkg::ST_KILL_LF;
               end else if (c == erase_ff) begin
                  ctl.pop = 1'b1;
               end else if ((c == lnle_pkg::CH_LF) || (c == lnle_pkg::CH_CR)) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{lnle_pkg::KIND_ECHO,
                                   (c == lnle_pkg::CH_CR) ? lnle_pkg::CH_LF : lnle_pkg::CH_CR,
                                   1'b0, 1'b0, 1'b0};
                  fold_in  = upper_ff && !lower_ff;
                  crm_in   = (c == lnle_pkg::CH_CR);
                  upper_in = 1'b0;
                  lower_in = 1'b0;
                  pend_in  = 1'b0;
                  state_in = is_empty ? lnle_pkg::ST_PROMPT : lnle_pkg::ST_NAME;
               end else begin
                  if (c inside {[lnle_pkg::CH_UPPER_A:lnle_pkg::CH_UPPER_Z]}) begin
                     upper_in = 1'b1;
                  end else if (c inside {[lnle_pkg::CH_LOWER_A:lnle_pkg::CH_LOWER_Z]}) begin
                     lower_in = 1'b1;
                  end
                  ctl.push = 1'b1;
               end
            end
         end
         lnle_pkg::ST_KILL_LF: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{lnle_pkg::KIND_ECHO, lnle_pkg::CH_LF, 1'b0, 1'b0, 1'b1};
               state_in     = lnle_pkg::ST_IDLE;
            end
         end
         lnle_pkg::ST_PROMPT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{lnle_pkg::KIND_PROMPT, '0, 1'b0, 1'b0, 1'b1};
               state_in     = lnle_pkg::ST_IDLE;
            end
         end
         lnle_pkg::ST_NAME: begin
            if (slot_free) begin
               ctl.shift    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{lnle_pkg::KIND_NAME, head_char,
                                head_last && fold_ff, head_last && crm_ff, head_last};
               if (head_last) begin
                  state_in = lnle_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = lnle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lnle_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         upper_ff     <= 1'b0;
         lower_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         fold_ff      <= 1'b0;
         crm_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         upper_ff     <= upper_in;
         lower_ff     <= lower_in;
         pend_ff      <= pend_in;
         fold_ff      <= fold_in;
         crm_ff       <= crm_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         intr_ff  <= lnle_pkg::INTR_RESET;
         eof_ff   <= lnle_pkg::EOF_RESET;
         kill_ff  <= lnle_pkg::KILL_RESET;
         erase_ff <= lnle_pkg::ERASE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lnle_pkg::CSR_INTR:  intr_ff  <= csr_wdata;
            lnle_pkg::CSR_EOF:   eof_ff   <= csr_wdata;
            lnle_pkg::CSR_KILL:  kill_ff  <= csr_wdata;
            lnle_pkg::CSR_ERASE: erase_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/lnle_cell.sv =====
module lnle_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  lnle_pkg::cell_ctl_type      ctl,
   input  logic                        prev_occ,
   input  logic                        next_occ,
   input  logic [lnle_pkg::CHAR_W-1:0] next_char,
   output logic                        occ,
   output logic [lnle_pkg::CHAR_W-1:0] char_out
);

   logic                        occ_ff;
   logic                        occ_in;
   logic [lnle_pkg::CHAR_W-1:0] char_ff;
   logic [lnle_pkg::CHAR_W-1:0] char_in;

   always_comb begin
      occ_in  = occ_ff;
      char_in = char_ff;
      if (ctl.clear) begin
         occ_in = 1'b0;
      end else if (ctl.shift) begin
         occ_in  = next_occ;
         char_in = next_char;
      end else if (ctl.push) begin
         // first free cell takes the new character
         if (prev_occ && !occ_ff) begin
            occ_in  = 1'b1;
            char_in = ctl.push_char;
         end
      end else if (ctl.pop) begin
         // last occupied cell lets go
         if (occ_ff && !next_occ) begin
            occ_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
   end

   assign occ      = occ_ff;
   assign char_out = char_ff;

endmodule

// ===== hw/rtl/lnle_checker.sv =====
`include "assert_macros.svh"

module lnle_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lnle_pkg::rsp_type rsp_data
);

   logic speed_out;
   logic mode_out;
   logic name_end;

   assign speed_out = rsp_valid && (rsp_data.kind == lnle_pkg::KIND_SPEED);
   assign mode_out  = rsp_valid && (rsp_data.lowercase_mode || rsp_data.cr_mode);
   assign name_end  = rsp_data.last && (rsp_data.kind == lnle_pkg::KIND_NAME);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPL(a_no_req_mid_run, clock, reset, rsp_valid && !rsp_data.last, !req_ready)
   `ASSERT_IMPL(a_speed_alone, clock, reset, speed_out, rsp_data.last && (rsp_data.out_char == '0))
   `ASSERT_IMPL(a_mode_on_name_end, clock, reset, mode_out, name_end)
   `ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind login_name_line_editor_unit lnle_checker u_lnle_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
